>>> design/tmpl_pkg.sv
// ----------------------------------------------------------------------------
// Traffic monitor package
// Shared types and constants for the traffic monitor with peer liveness table.
// ----------------------------------------------------------------------------
package tmpl_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_FRAME = 2'd0,
    REQ_ERROR = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_PEER_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_OWN_ADDRESS  = 2'd1;
  localparam logic [1:0] REG_RATE_WINDOW  = 2'd2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register reset values.
  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
  localparam logic [7:0]  OWN_RESET     = 8'd0;
  localparam logic [15:0] WINDOW_RESET  = 16'd1000;

  // Field widths.
  localparam int ADDR_W   = 8;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 16;
  localparam int ONLINE_W = 7;

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    req_kind_t         kind;
    logic              roll;     // item may roll the rate window
    logic              refresh;  // frame whose sender goes into the table
    logic [ADDR_W-1:0] node_addr;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  // One entry of the peer slot memory.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] seen;
  } slot_entry_t;

endpackage

>>> design/tmpl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmpl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tmpl_front.sv
// ----------------------------------------------------------------------------
// Traffic monitor front end
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
module tmpl_front import tmpl_pkg::*; (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [ADDR_W-1:0] node_addr,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [ADDR_W-1:0] own_address,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  req_kind_t kind;

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign kind     = req_kind_t'(req_type);

  // Classify the transaction.
  always_comb begin
    push_cmd           = '0;
    push_cmd.kind      = kind;
    push_cmd.node_addr = node_addr;
    push_cmd.now_ms    = now_ms;
    push_cmd.roll      = kind inside {REQ_FRAME, REQ_QUERY};
    case (kind)
      REQ_FRAME: push_cmd.refresh = (node_addr != own_address);
      default:   push_cmd.refresh = 1'b0;
    endcase
  end

endmodule

>>> design/tmpl_queue.sv
// ----------------------------------------------------------------------------
// Traffic monitor command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tmpl_queue import tmpl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic              pop,
  output logic              q_valid,
  output cmd_t              q_cmd,
  output logic              q_full,
  output logic [QCNT_W-1:0] q_count
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign q_valid = (q_count != '0);
  assign q_full  = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign q_cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

>>> design/tmpl_back.sv
// ----------------------------------------------------------------------------
// Traffic monitor back end
// Updates counters and the rate window, scans the peer slot memory one slot
// per cycle, and holds the result transaction in an output register.
// ----------------------------------------------------------------------------
module tmpl_back import tmpl_pkg::*; #(
  parameter int PEER_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TIME_W-1:0]   peer_timeout_ms,
  input  logic [RATE_W-1:0]   rate_window_ms,
  input  logic                q_valid,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TIME_W-1:0]   total_frames,
  output logic [TIME_W-1:0]   error_total,
  output logic [RATE_W-1:0]   frames_per_window,
  output logic [ONLINE_W-1:0] online_count,
  output logic                queried_online
);

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int ISS_W = IDX_W + 1;
  localparam int CNT_W = $clog2(PEER_SLOTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ALLOC = 4'b0100,
    ST_FIN   = 4'b1000
  } back_state_t;

  back_state_t       state;
  cmd_t              cmd;
  logic [ISS_W-1:0]  iss;
  logic              rd_pending;
  logic [IDX_W-1:0]  proc_idx;
  logic              hit_found;
  logic              have_free;
  logic [IDX_W-1:0]  open_slot;
  logic [CNT_W-1:0]  online;
  logic              queried;
  logic [PEER_SLOTS-1:0] slot_valid;

  logic [TIME_W-1:0] frame_total;
  logic [TIME_W-1:0] error_count;
  logic [TIME_W-1:0] window_start_ms;
  logic [RATE_W-1:0] window_frames;
  logic [RATE_W-1:0] last_window_rate;

  slot_entry_t       rd_entry;
  slot_entry_t       wr_entry;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;

  logic              slot_live;
  logic              hit;
  logic              upd_hit;
  logic [TIME_W-1:0] age;
  logic              fresh;
  logic              tmo_nz;
  logic              counted;
  logic              last_slot;
  logic              alloc_go;
  logic [TIME_W-1:0] elapsed;
  logic              roll_hit;
  logic              res_load;

  // Peer slot memory: address and last-seen time of each slot.
  tmpl_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (PEER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // Per-slot evaluation of the entry read back from memory.
  assign slot_live = rd_pending && slot_valid[proc_idx];
  assign hit       = slot_live && (rd_entry.addr == cmd.node_addr);
  assign upd_hit   = hit && cmd.refresh;
  assign age       = cmd.now_ms - rd_entry.seen;
  assign fresh     = age < peer_timeout_ms;
  assign tmo_nz    = (peer_timeout_ms != '0);
  assign counted   = upd_hit ? tmo_nz : (slot_live && fresh);
  assign last_slot = rd_pending && (proc_idx == IDX_W'(PEER_SLOTS - 1));

  // A new sender takes the lowest free slot after the scan.
  assign alloc_go  = (state == ST_ALLOC) && cmd.refresh && !hit_found && have_free;

  // Memory write: refresh on a hit, or fill the claimed slot.
  assign ram_we    = ((state == ST_SCAN) && upd_hit) || alloc_go;
  assign ram_waddr = alloc_go ? open_slot : proc_idx;
  assign wr_entry  = '{addr: cmd.node_addr, seen: cmd.now_ms};

  // Rate window test on the command at the queue head.
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign elapsed  = q_cmd.now_ms - window_start_ms;
  assign roll_hit = q_cmd.roll && (elapsed >= {{(TIME_W - RATE_W){1'b0}}, rate_window_ms});

  // The result register takes a new transaction once the old one has left.
  assign res_load = (state == ST_FIN) && (!out_valid || out_ready);

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      iss              <= '0;
      rd_pending       <= 1'b0;
      slot_valid       <= '0;
      frame_total      <= '0;
      error_count      <= '0;
      window_start_ms  <= '0;
      window_frames    <= '0;
      last_window_rate <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            iss        <= ISS_W'(1);
            rd_pending <= 1'b1;
            proc_idx   <= '0;
            hit_found  <= 1'b0;
            have_free  <= 1'b0;
            open_slot  <= '0;
            online     <= '0;
            queried    <= 1'b0;
            case (q_cmd.kind)
              REQ_FRAME: begin
                frame_total <= frame_total + 1'b1;
                if (roll_hit) begin
                  last_window_rate <= window_frames;
                  window_frames    <= RATE_W'(1);
                  window_start_ms  <= q_cmd.now_ms;
                end else begin
                  window_frames <= window_frames + 1'b1;
                end
              end
              REQ_ERROR: begin
                error_count <= error_count + 1'b1;
              end
              REQ_QUERY: begin
                if (roll_hit) begin
                  last_window_rate <= window_frames;
                  window_frames    <= '0;
                  window_start_ms  <= q_cmd.now_ms;
                end
              end
              default: ;
            endcase
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue the next slot read while the previous one is evaluated.
          if (last_slot) begin
            rd_pending <= 1'b0;
            iss        <= '0;
            state      <= ST_ALLOC;
          end else if (iss < ISS_W'(PEER_SLOTS)) begin
            rd_pending <= 1'b1;
            proc_idx   <= iss[IDX_W-1:0];
            iss        <= iss + 1'b1;
          end else begin
            rd_pending <= 1'b0;
          end
          if (rd_pending) begin
            online <= online + CNT_W'(counted);
            if (upd_hit) begin
              hit_found <= 1'b1;
            end
            if ((cmd.kind == REQ_QUERY) && hit) begin
              queried <= fresh;
            end
            if (!slot_valid[proc_idx] && !have_free) begin
              have_free <= 1'b1;
              open_slot <= proc_idx;
            end
          end
        end
        ST_ALLOC: begin
          if (alloc_go) begin
            slot_valid[open_slot] <= 1'b1;
            online                <= online + CNT_W'(tmo_nz);
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded when the result register takes a transaction.
  always_ff @(posedge clk) begin
    if (res_load) begin
      total_frames      <= frame_total;
      error_total       <= error_count;
      frames_per_window <= last_window_rate;
      online_count      <= ONLINE_W'(online);
      queried_online    <= queried;
    end
  end

endmodule

>>> design/traffic_monitor_peer_liveness.sv
// ----------------------------------------------------------------------------
// Traffic monitor with peer liveness
// Frame and error counters, rate window and peer last-seen table.
// ----------------------------------------------------------------------------
// Each transaction (frame, error or liveness query) returns one result with
// the frame and error totals, the frame count of the last completed rate
// window, the number of online peers and, for a query, whether the queried
// address is online. The front end takes a transaction in any cycle the
// two-entry command queue has room. The back end handles one transaction at
// a time: a dispatch step, a scan of each peer slot in turn through the single
// read port of the slot memory, a step to claim a free slot and a step to load
// the result register. No clearing pass is needed after reset: slot valid bits
// reset at once. Configuration registers sit on the APB port at byte
// addresses 0x0 (peer timeout), 0x4 (own address) and 0x8 (rate window).
module traffic_monitor_peer_liveness import tmpl_pkg::*; #(
  parameter int PEER_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [ADDR_W-1:0]   node_addr,
  input  logic [TIME_W-1:0]   now_ms,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TIME_W-1:0]   total_frames,
  output logic [TIME_W-1:0]   error_total,
  output logic [RATE_W-1:0]   frames_per_window,
  output logic [ONLINE_W-1:0] online_count,
  output logic                queried_online
);

  logic [TIME_W-1:0] peer_timeout_ms;
  logic [ADDR_W-1:0] own_address;
  logic [RATE_W-1:0] rate_window_ms;
  logic              cfg_write;
  logic [1:0]        reg_idx;

  logic              push;
  cmd_t              push_cmd;
  logic              q_pop;
  logic              q_valid;
  cmd_t              q_cmd;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_timeout_ms <= TIMEOUT_RESET;
      own_address     <= OWN_RESET;
      rate_window_ms  <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_PEER_TIMEOUT: peer_timeout_ms <= pwdata;
        REG_OWN_ADDRESS:  own_address     <= pwdata[ADDR_W-1:0];
        REG_RATE_WINDOW:  rate_window_ms  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_PEER_TIMEOUT: prdata = peer_timeout_ms;
      REG_OWN_ADDRESS:  prdata = {{(PDATA_W - ADDR_W){1'b0}}, own_address};
      REG_RATE_WINDOW:  prdata = {{(PDATA_W - RATE_W){1'b0}}, rate_window_ms};
      default:          prdata = '0;
    endcase
  end

  // Front end: accept and classify.
  tmpl_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .node_addr   (node_addr),
    .now_ms      (now_ms),
    .own_address (own_address),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Command queue.
  tmpl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_full   (q_full),
    .q_count  (q_count)
  );

  // Back end: counters, window and peer table.
  tmpl_back #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .peer_timeout_ms   (peer_timeout_ms),
    .rate_window_ms    (rate_window_ms),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .total_frames      (total_frames),
    .error_total       (error_total),
    .frames_per_window (frames_per_window),
    .online_count      (online_count),
    .queried_online    (queried_online)
  );

  // The online count never exceeds the number of peer slots.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (online_count <= ONLINE_W'(PEER_SLOTS)))
    else $error("online count exceeds peer slot count");

  // The back end only takes a command from a non-empty queue.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("command taken from empty queue");

  // A push without a pop grows the queue by exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> (q_count == $past(q_count) + QCNT_W'(1)))
    else $error("queue occupancy out of step with pushes");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic monitor with peer liveness: testbench
// Drives frame, error, query and unused transactions through the input
// channel, gets expected results typed in or from its own model of the counters,
// rate window and peer table, and checks each result as it leaves the block.
// A short table of directed transactions comes first. Random phases with
// different register settings and handshake idling follow, one of them with
// a long result stall that fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import tmpl_pkg::*;

  localparam int PEER_SLOTS     = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  // One result of the block, in port order.
  typedef struct packed {
    logic [TIME_W-1:0]   frames;
    logic [TIME_W-1:0]   errors;
    logic [RATE_W-1:0]   rate;
    logic [ONLINE_W-1:0] online;
    logic                queried;
  } liveness_status_t;

  // One directed transaction, with its result typed in where it is obvious.
  typedef struct packed {
    req_kind_t          req;
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  now;
    logic               typed;
    liveness_status_t   status;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          req_type = '0;
  logic [ADDR_W-1:0]   node_addr = '0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TIME_W-1:0]   total_frames;
  logic [TIME_W-1:0]   error_total;
  logic [RATE_W-1:0]   frames_per_window;
  logic [ONLINE_W-1:0] online_count;
  logic                queried_online;

  // Model state of the block and its registers.
  logic                slot_used [PEER_SLOTS];
  logic [ADDR_W-1:0]   slot_addr [PEER_SLOTS];
  logic [TIME_W-1:0]   slot_seen [PEER_SLOTS];
  logic [TIME_W-1:0]   frame_tally = '0;
  logic [TIME_W-1:0]   error_tally = '0;
  logic [TIME_W-1:0]   win_start = '0;
  logic [RATE_W-1:0]   win_frames = '0;
  logic [RATE_W-1:0]   win_rate = '0;
  logic [TIME_W-1:0]   cfg_timeout = TIMEOUT_RESET;
  logic [ADDR_W-1:0]   cfg_own = OWN_RESET;
  logic [RATE_W-1:0]   cfg_window = WINDOW_RESET;

  liveness_status_t    status_due [$];
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic [TIME_W-1:0]   clock_ms = 32'd6210;
  logic                hold_trigger = 1'b0;
  logic                hold_seen = 1'b0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;

  // Directed transactions: empty block, extremes, own address, aging out,
  // filling the peer table, a sender dropped by the full table, unused code.
  stim_row_t directed_rows [25] = '{
    '{REQ_QUERY, 8'd0,   32'd0,          1'b1, '{32'd0, 32'd0, 16'd0, 7'd0, 1'b0}},
    '{REQ_ERROR, 8'd255, 32'hFFFF_FFFF,  1'b1, '{32'd0, 32'd1, 16'd0, 7'd0, 1'b0}},
    '{REQ_FRAME, 8'd0,   32'd10,         1'b1, '{32'd1, 32'd1, 16'd0, 7'd0, 1'b0}},
    '{REQ_FRAME, 8'd255, 32'd20,         1'b1, '{32'd2, 32'd1, 16'd0, 7'd1, 1'b0}},
    '{REQ_QUERY, 8'd255, 32'd30,         1'b1, '{32'd2, 32'd1, 16'd0, 7'd1, 1'b1}},
    '{REQ_QUERY, 8'd255, 32'd5020,       1'b1, '{32'd2, 32'd1, 16'd2, 7'd0, 1'b0}},
    '{REQ_NONE,  8'hAA,  32'h5555_5555,  1'b1, '{32'd2, 32'd1, 16'd2, 7'd0, 1'b0}},
    '{REQ_FRAME, 8'd1,   32'd6000,       1'b0, '0},
    '{REQ_FRAME, 8'd2,   32'd6010,       1'b0, '0},
    '{REQ_FRAME, 8'd3,   32'd6020,       1'b0, '0},
    '{REQ_FRAME, 8'd4,   32'd6030,       1'b0, '0},
    '{REQ_FRAME, 8'd5,   32'd6040,       1'b0, '0},
    '{REQ_FRAME, 8'd6,   32'd6050,       1'b0, '0},
    '{REQ_FRAME, 8'd7,   32'd6060,       1'b0, '0},
    '{REQ_FRAME, 8'd8,   32'd6070,       1'b0, '0},
    '{REQ_FRAME, 8'd9,   32'd6080,       1'b0, '0},
    '{REQ_FRAME, 8'd10,  32'd6090,       1'b0, '0},
    '{REQ_FRAME, 8'd11,  32'd6100,       1'b0, '0},
    '{REQ_FRAME, 8'd12,  32'd6110,       1'b0, '0},
    '{REQ_FRAME, 8'd13,  32'd6120,       1'b0, '0},
    '{REQ_FRAME, 8'd14,  32'd6130,       1'b0, '0},
    '{REQ_FRAME, 8'd15,  32'd6140,       1'b0, '0},
    '{REQ_FRAME, 8'd200, 32'd6200,       1'b0, '0},
    '{REQ_QUERY, 8'd200, 32'd6210,       1'b0, '0},
    '{REQ_QUERY, 8'd1,   32'd6210,       1'b0, '0}
  };

  traffic_monitor_peer_liveness #(
    .PEER_SLOTS(PEER_SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .node_addr        (node_addr),
    .now_ms           (now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .total_frames     (total_frames),
    .error_total      (error_total),
    .frames_per_window(frames_per_window),
    .online_count     (online_count),
    .queried_online   (queried_online)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_addr[i] = '0;
      slot_seen[i] = '0;
    end
  end

  // Counts the failure and prints the first few of them.
  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // Updates the model for one transaction and returns the result it causes.
  function automatic liveness_status_t predict_status(input req_kind_t req,
      input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
    liveness_status_t  status;
    int                free_slot;
    logic              found;
    logic [TIME_W-1:0] age;
    status = '0;
    free_slot = -1;
    found = 1'b0;
    // Frames and queries close the rate window once it has run out.
    if (req == REQ_FRAME || req == REQ_QUERY) begin
      age = now - win_start;
      if (age >= TIME_W'(cfg_window)) begin
        win_rate = win_frames;
        win_frames = '0;
        win_start = now;
      end
    end
    case (req)
      REQ_FRAME: begin
        frame_tally++;
        win_frames++;
        // Refresh the sender's slot, or claim the lowest free one.
        if (addr != cfg_own) begin
          for (int i = 0; i < PEER_SLOTS; i++) begin
            if (!found && slot_used[i] && slot_addr[i] == addr) begin
              slot_seen[i] = now;
              found = 1'b1;
            end else if (!found && !slot_used[i] && free_slot < 0) begin
              free_slot = i;
            end
          end
          if (!found && free_slot >= 0) begin
            slot_used[free_slot] = 1'b1;
            slot_addr[free_slot] = addr;
            slot_seen[free_slot] = now;
          end
        end
      end
      REQ_ERROR: begin
        error_tally++;
      end
      REQ_QUERY: begin
        for (int i = 0; i < PEER_SLOTS; i++) begin
          age = now - slot_seen[i];
          if (slot_used[i] && slot_addr[i] == addr && age < cfg_timeout) begin
            status.queried = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // Ages are taken at this transaction's time, after its update.
    for (int i = 0; i < PEER_SLOTS; i++) begin
      age = now - slot_seen[i];
      if (slot_used[i] && age < cfg_timeout) begin
        status.online++;
      end
    end
    status.frames = frame_tally;
    status.errors = error_tally;
    status.rate = win_rate;
    return status;
  endfunction

  // Offers one transaction after a random idle gap and waits until it is taken.
  task automatic drive_item(input req_kind_t req, input logic [ADDR_W-1:0] addr,
      input logic [TIME_W-1:0] now, input logic typed, input liveness_status_t typed_status);
    liveness_status_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    node_addr <= addr;
    now_ms    <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = predict_status(req, addr, now);
    status_due.push_back(typed ? typed_status : due);
  endtask

  // Stops offering and waits until every result is back and the block is idle.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register, then reads it back through the same port.
  task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask;
    mask = (idx == REG_PEER_TIMEOUT) ? 32'hFFFF_FFFF :
           (idx == REG_OWN_ADDRESS) ? 32'h0000_00FF : 32'h0000_FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write completes at this edge; the access turns into a read.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      note_failure($sformatf("register %0d read back %h, expected %h",
                             idx, prdata & mask, value & mask));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PEER_TIMEOUT: cfg_timeout = value;
      REG_OWN_ADDRESS:  cfg_own = value[ADDR_W-1:0];
      default:          cfg_window = value[RATE_W-1:0];
    endcase
    @(posedge clk);
  endtask

  // One random phase: new settings, handshake idling, then random transactions.
  // Times mostly creep forward so peers age across the timeout, with some
  // jumps, some steps back and some stray times.
  task automatic run_phase(input logic [TIME_W-1:0] timeout, input logic [ADDR_W-1:0] own,
      input logic [RATE_W-1:0] window, input int send_idle, input int recv_stall,
      input int step_max, input int items, input logic squeeze);
    req_kind_t         req;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    int                pick;
    settle_idle();
    write_register(REG_PEER_TIMEOUT, timeout);
    write_register(REG_OWN_ADDRESS, {24'd0, own});
    write_register(REG_RATE_WINDOW, {16'd0, window});
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    if (squeeze) begin
      hold_trigger <= ~hold_trigger;
    end
    repeat (items) begin
      pick = $urandom_range(0, 99);
      req = (pick < 50) ? REQ_FRAME : (pick < 62) ? REQ_ERROR :
            (pick < 95) ? REQ_QUERY : REQ_NONE;
      // Mostly addresses already in the table, then our own, then any.
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        addr = 8'($urandom_range(0, 16));
        if (addr == 8'd16) begin
          addr = 8'hFF;
        end
      end else if (pick < 80) begin
        addr = cfg_own;
      end else begin
        addr = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        clock_ms += $urandom_range(0, step_max);
      end else if (pick < 91) begin
        clock_ms = $urandom;
      end else if (pick < 95) begin
        clock_ms -= $urandom_range(0, step_max);
      end
      now = (pick >= 95) ? $urandom : clock_ms;
      drive_item(req, addr, now, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    liveness_status_t got;
    liveness_status_t want;
    if (!rst && out_valid && out_ready) begin
      got = {total_frames, error_total, frames_per_window, online_count, queried_online};
      if (status_due.size() == 0) begin
        note_failure($sformatf("result with nothing outstanding: %h", got));
      end else begin
        want = status_due.pop_front();
        if (got !== want) begin
          note_failure($sformatf({"result mismatch: expected frames %0d errors %0d rate %0d",
                                  " online %0d queried %0d, got %0d %0d %0d %0d %0d"},
                                 want.frames, want.errors, want.rate, want.online,
                                 want.queried, got.frames, got.errors, got.rate,
                                 got.online, got.queried));
        end
      end
    end
  end

  // Ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].req, directed_rows[i].addr, directed_rows[i].now,
                 directed_rows[i].typed, directed_rows[i].status);
    end
    run_phase(32'd5000, 8'd0, 16'd1000, 0, 0, 300, 200, 1'b0);
    run_phase(32'd1500, 8'd5, 16'd300, 86, 0, 150, 200, 1'b0);
    run_phase(32'd0, 8'd255, 16'd0, 0, 86, 100, 150, 1'b0);
    run_phase(32'hFFFF_FFFF, 8'd0, 16'd65535, 31, 31, 3000, 200, 1'b0);
    run_phase(32'd700, 8'($urandom_range(0, 255)), 16'd1, 0, 0, 80, 200, 1'b1);
    run_phase($urandom, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)),
              0, 86, 2000, 250, 1'b0);
    run_phase(32'd2500, 8'd10, 16'd500, 31, 31, 200, 225, 1'b0);
    settle_idle();
    if (mismatch_count == 0 && status_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
